FILE: hdl/c32tc_pkg.sv
package c32tc_pkg;

   // Reflected CRC-32 constants
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   // Field widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CRC_W      = 32;
   localparam int unsigned RSP_FIELD_W = STATUS_W + 2 * CRC_W;
   localparam int unsigned RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // Marker "CRC32 " and parser limits
   localparam int unsigned MARKER_LEN = 6;
   localparam int unsigned HEX_DIGITS = 8;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   typedef enum logic [STATUS_W-1:0] {
      ST_PASS      = 3'd0,
      ST_NO_MARKER = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_BAD_HEX   = 3'd3,
      ST_MISMATCH  = 3'd4
   } c32tc_status_type;

   typedef struct packed {
      logic [CRC_W-1:0] expected_crc;
      logic [CRC_W-1:0] computed_crc;
      c32tc_status_type status;
   } c32tc_result_type;

   // One byte through the reflected CRC, bit by bit
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_cur,
                                                 input logic [BYTE_W-1:0] data);
      logic [CRC_W-1:0] crc_v;
      crc_v = crc_cur ^ {{(CRC_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         crc_v = (crc_v >> 1) ^ (crc_v[0] ? CRC_POLY : '0);
      end
      return crc_v;
   endfunction

   // Expected character at a given marker position
   function automatic logic [7:0] marker_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h43;
         3'd1:    ch = 8'h52;
         3'd2:    ch = 8'h43;
         3'd3:    ch = 8'h33;
         3'd4:    ch = 8'h32;
         3'd5:    ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: hdl/c32tc_core.sv
module c32tc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_valid,
   input  logic [7:0]                  step_byte,
   input  logic                        step_last,
   output c32tc_pkg::c32tc_result_type step_result
);
   import c32tc_pkg::*;

   logic [CRC_W-1:0] running_crc_ff, running_crc_in;
   logic [CRC_W-1:0] line_start_crc_ff, line_start_crc_in;
   logic             at_line_start_ff, at_line_start_in;
   logic [2:0]       marker_progress_ff, marker_progress_in;
   logic             marker_found_ff, marker_found_in;
   logic [CRC_W-1:0] candidate_crc_ff, candidate_crc_in;
   logic [3:0]       hex_digits_seen_ff, hex_digits_seen_in;
   logic [CRC_W-1:0] hex_value_ff, hex_value_in;
   logic             hex_invalid_ff, hex_invalid_in;

   logic [3:0]       nibble;
   logic             nibble_bad;
   logic [CRC_W-1:0] computed;

   // Hex digit decode, uppercase only
   always_comb begin
      nibble     = '0;
      nibble_bad = 1'b0;
      if (step_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
         nibble = step_byte[3:0];
      end else if (step_byte inside {[CHAR_UPPER_A:CHAR_UPPER_F]}) begin
         nibble = step_byte[3:0] + 4'd9;
      end else begin
         nibble_bad = 1'b1;
      end
   end

   // Per-byte state update and result
   always_comb begin
      running_crc_in     = running_crc_ff;
      line_start_crc_in  = line_start_crc_ff;
      at_line_start_in   = at_line_start_ff;
      marker_progress_in = marker_progress_ff;
      marker_found_in    = marker_found_ff;
      candidate_crc_in   = candidate_crc_ff;
      hex_digits_seen_in = hex_digits_seen_ff;
      hex_value_in       = hex_value_ff;
      hex_invalid_in     = hex_invalid_ff;
      computed           = '0;
      step_result        = '{expected_crc: '0, computed_crc: '0, status: ST_NO_MARKER};

      if (step_valid) begin
         // snapshot at line start
         if (at_line_start_ff) begin
            line_start_crc_in = running_crc_ff;
         end

         // digits after the current marker
         if (marker_found_ff && !hex_digits_seen_ff[3]) begin
            hex_invalid_in     = hex_invalid_ff | nibble_bad;
            hex_value_in       = {hex_value_ff[CRC_W-5:0], nibble};
            hex_digits_seen_in = hex_digits_seen_ff + 4'd1;
         end

         // marker match, only from a line start
         if (at_line_start_ff) begin
            marker_progress_in = '0;
         end
         if (at_line_start_ff || marker_progress_ff != '0) begin
            if (step_byte == marker_char(marker_progress_in)) begin
               if (marker_progress_in == 3'(MARKER_LEN - 1)) begin
                  marker_found_in    = 1'b1;
                  candidate_crc_in   = line_start_crc_in;
                  hex_digits_seen_in = '0;
                  hex_value_in       = '0;
                  hex_invalid_in     = 1'b0;
                  marker_progress_in = '0;
               end else begin
                  marker_progress_in = marker_progress_in + 3'd1;
               end
            end else begin
               marker_progress_in = '0;
            end
         end

         running_crc_in   = crc_byte(running_crc_ff, step_byte);
         at_line_start_in = (step_byte == CHAR_NEWLINE);

         // result after this byte; the top keeps it only on the final byte
         if (marker_found_in) begin
            computed                 = candidate_crc_in ^ CRC_ONES;
            step_result.computed_crc = computed;
            step_result.expected_crc = hex_value_in;
            if (!hex_digits_seen_in[3]) begin
               step_result.status = ST_TRUNCATED;
            end else if (hex_invalid_in) begin
               step_result.status = ST_BAD_HEX;
            end else if (computed == hex_value_in) begin
               step_result.status = ST_PASS;
            end else begin
               step_result.status = ST_MISMATCH;
            end
         end

         // back to the start state for the next transcript
         if (step_last) begin
            running_crc_in     = CRC_ONES;
            line_start_crc_in  = CRC_ONES;
            at_line_start_in   = 1'b1;
            marker_progress_in = '0;
            marker_found_in    = 1'b0;
            candidate_crc_in   = '0;
            hex_digits_seen_in = '0;
            hex_value_in       = '0;
            hex_invalid_in     = 1'b0;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff     <= CRC_ONES;
         line_start_crc_ff  <= CRC_ONES;
         at_line_start_ff   <= 1'b1;
         marker_progress_ff <= '0;
         marker_found_ff    <= 1'b0;
         candidate_crc_ff   <= '0;
         hex_digits_seen_ff <= '0;
         hex_value_ff       <= '0;
         hex_invalid_ff     <= 1'b0;
      end else begin
         running_crc_ff     <= running_crc_in;
         line_start_crc_ff  <= line_start_crc_in;
         at_line_start_ff   <= at_line_start_in;
         marker_progress_ff <= marker_progress_in;
         marker_found_ff    <= marker_found_in;
         candidate_crc_ff   <= candidate_crc_in;
         hex_digits_seen_ff <= hex_digits_seen_in;
         hex_value_ff       <= hex_value_in;
         hex_invalid_ff     <= hex_invalid_in;
      end
   end

   // a final byte leaves the start state behind
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      step_valid && step_last |=> at_line_start_ff && !marker_found_ff
                                  && running_crc_ff == CRC_ONES)
      else $error("state not restarted after final byte");

   // a match in progress never reaches the full marker length
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      marker_progress_ff < 3'(MARKER_LEN))
      else $error("marker progress out of range");

   // the digit count saturates at eight
   a_digits_range: assert property (@(posedge clock) disable iff (reset)
      hex_digits_seen_ff <= 4'(HEX_DIGITS))
      else $error("hex digit count past eight");

endmodule

FILE: hdl/crc32_trailer_checker_top.sv
// Channel | Direction | Ports                              | Content
// req     | in        | req_tvalid/tready/tdata/tlast      | data_byte, last_byte on tlast
// rsp     | out       | rsp_tvalid/tready/tdata            | status, computed_crc, expected_crc
//
// One byte per cycle sustained; a byte goes input register -> CRC/parse stage -> result
// register, so a result is valid once the final byte has passed the CRC/parse stage into it.
// The byte CRC, marker match and hex parse are all done in the one stage behind the
// input register; only a final byte waits, and only while a full result is not accepted.
// Synchronous active-high reset returns to the start of a transcript; no clearing pass.
module crc32_trailer_checker_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] data_byte
   input  logic                              req_tlast,  // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [c32tc_pkg::RSP_DATA_W-1:0]  rsp_tdata   // [2:0] status, [34:3] computed_crc,
                                                         // [66:35] expected_crc, rest zero
);
   import c32tc_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic             out_valid_ff, out_valid_in;
   c32tc_result_type out_data_ff;
   c32tc_result_type step_result;
   logic             advance;
   logic             load_out;

   // the stage moves unless a final byte finds the result register full and not accepted
   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign load_out   = advance && in_last_ff;
   assign req_tready = !in_valid_ff || advance;

   c32tc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_byte  (in_byte_ff),
      .step_last  (in_last_ff),
      .step_result(step_result)
   );

   // Valid flags
   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (load_out) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_data_ff};

   // the input stage only stalls behind a full, unaccepted result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> in_last_ff && out_valid_ff && !rsp_tready)
      else $error("input stage stalled without cause");

   // a processed final byte always lands in the result register
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      load_out |=> out_valid_ff)
      else $error("final byte produced no result");

   // pass means the two values agree
   a_pass_equal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.status == ST_PASS
      |-> out_data_ff.computed_crc == out_data_ff.expected_crc)
      else $error("pass reported on differing values");

   // without a marker both values are zero
   a_no_marker_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.status == ST_NO_MARKER
      |-> out_data_ff.computed_crc == '0 && out_data_ff.expected_crc == '0)
      else $error("no-marker result carries values");

endmodule
